@@ design/mpm_pkg.sv @@
// Package: shared types, constants and request codes for the pattern matcher.
`default_nettype none
package mpm_pkg;
	localparam int MAX_RULES_D    = 16;
	localparam int MAX_FRAGS_D    = 4;
	localparam int MAX_FRAG_LEN_D = 16;

	typedef enum logic [1:0] {
		REQ_SUBJECT = 2'd0,
		REQ_HEADER  = 2'd1,
		REQ_PATTERN = 2'd2,
		REQ_LENGTH  = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  rule_index;
		logic [1:0]  frag_index;
		logic [3:0]  byte_pos;
		logic [7:0]  byte_value;
		logic [4:0]  frag_length;
		logic [7:0]  rule_score;
		logic [7:0]  rule_status;
		logic [2:0]  frag_count;
		logic [15:0] rule_tag;
		logic        last_byte;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  hit_rule;
		logic [15:0] hit_tag;
		logic [7:0]  hit_score;
		logic [7:0]  hit_status;
	} out_item_t;

	// Subject byte with valid and last flags.
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} sbyte_t;
endpackage
`default_nettype wire

@@ design/mpm_cell.sv @@
// Cell: one window tap plus the pattern bytes of every fragment at that offset.
`default_nettype none
module mpm_cell import mpm_pkg::*; #(
	parameter int NSLOT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [$clog2(NSLOT > 1 ? NSLOT : 2)-1:0] wr_slot,
	input  wire logic [7:0]         wr_data,
	input  wire logic               shift,
	input  wire logic               clear,
	input  wire logic [7:0]         din,
	output logic [7:0]              dout,
	output logic [NSLOT-1:0][7:0]   pat
);
	logic [7:0] win_q;
	logic [NSLOT-1:0][7:0] pat_q;

	// Advance the window by one byte; drop it after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (clear) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= din;
		end
	end

	// Hold pattern bytes of this offset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q[wr_slot] <= wr_data;
		end
	end

	assign dout = win_q;
	assign pat  = pat_q;
endmodule
`default_nettype wire

@@ design/multi_pattern_and_rule_matcher_unit.sv @@
// Top level: rule table, cell chain, found flags and result register.
// Result: a last subject byte gives its result in the cycle after acceptance.
// Throughput: one request per cycle unless in_stall holds it; all fragments are
// compared in parallel, combinationally, against the window and the cell patterns.
// Reset: arst_n clears rule table, lengths, window, flags and active_q;
// pattern bytes are undefined until written.
`default_nettype none
module multi_pattern_and_rule_matcher_unit import mpm_pkg::*; #(
	parameter int MAX_RULES    = MAX_RULES_D,
	parameter int MAX_FRAGS    = MAX_FRAGS_D,
	parameter int MAX_FRAG_LEN = MAX_FRAG_LEN_D
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [4:0] cfg_data
);
	localparam int NSLOT = MAX_RULES * MAX_FRAGS;
	localparam int SW    = $clog2(NSLOT > 1 ? NSLOT : 2);
	localparam int LW    = $clog2(MAX_FRAG_LEN + 1);

	logic [4:0]  active_q;
	logic [LW-1:0] len_q [NSLOT];
	logic [7:0]  score_q [MAX_RULES];
	logic [7:0]  status_q [MAX_RULES];
	logic [2:0]  cnt_q [MAX_RULES];
	logic [15:0] tag_q [MAX_RULES];
	logic [NSLOT-1:0] found_q;
	logic [LW-1:0] seen_q;
	out_item_t   res_q;
	logic        res_v_q;

	logic acc, subj, last_sub;
	logic [SW-1:0] slot;
	logic addr_ok_r, addr_ok_f, addr_ok_p;
	logic [7:0] win [MAX_FRAG_LEN+1];
	logic [NSLOT-1:0][7:0] pat_all [MAX_FRAG_LEN];
	logic [NSLOT-1:0] match, found_nx;
	logic [LW-1:0] seen_nx;
	out_item_t res_nx;

	assign in_stall  = res_v_q && out_stall;
	assign acc       = in_valid && !in_stall;
	assign subj      = acc && (in_data.req_type == REQ_SUBJECT);
	assign last_sub  = subj && in_data.last_byte;
	assign cfg_ready = 1'b1;
	assign addr_ok_r = 32'(in_data.rule_index) < MAX_RULES;
	assign addr_ok_f = addr_ok_r && (32'(in_data.frag_index) < MAX_FRAGS);
	assign addr_ok_p = addr_ok_f && (32'(in_data.byte_pos) < MAX_FRAG_LEN);
	assign slot = SW'(32'(in_data.rule_index) * MAX_FRAGS + 32'(in_data.frag_index));

	// Chain of cells: cell k holds window byte k and pattern byte k of every slot.
	assign win[0] = in_data.byte_value;
	for (genvar k = 0; k < MAX_FRAG_LEN; k++) begin : g_cell
		mpm_cell #(.NSLOT(NSLOT)) u_cell (
			.clk, .arst_n,
			.wr_en  (acc && in_data.req_type == REQ_PATTERN && addr_ok_p &&
			         32'(in_data.byte_pos) == k),
			.wr_slot(slot),
			.wr_data(in_data.byte_value),
			.shift  (subj && !in_data.last_byte),
			.clear  (last_sub),
			.din    (win[k]),
			.dout   (win[k+1]),
			.pat    (pat_all[k])
		);
	end

	// Pattern byte k is compared against the window byte at len-1-k.
	always_comb begin
		logic [LW-1:0] wi;
		wi = '0;
		for (int s = 0; s < NSLOT; s++) begin
			match[s] = 1'b1;
			if (len_q[s] != '0) begin
				if ((32'(seen_q) + 1) < 32'(len_q[s]) &&
				    !(32'(seen_q) >= MAX_FRAG_LEN)) begin
					match[s] = 1'b0;
				end
				for (int k = 0; k < MAX_FRAG_LEN; k++) begin
					if (k < 32'(len_q[s])) begin
						wi = len_q[s] - LW'(1) - LW'(k);
						if (pat_all[k][s] != win[wi]) begin
							match[s] = 1'b0;
						end
					end
				end
			end
		end
	end

	assign found_nx = found_q | match;
	assign seen_nx  = (32'(seen_q) < MAX_FRAG_LEN) ? seen_q + 1'b1 : seen_q;

	// Priority pick of the lowest active rule with all fragments found.
	always_comb begin
		logic done, all;
		done = 1'b0;
		res_nx = '0;
		for (int r = 0; r < MAX_RULES; r++) begin
			all = (cnt_q[r] != 3'd0);
			for (int j = 0; j < MAX_FRAGS; j++) begin
				if (j < 32'(cnt_q[r]) && !found_nx[r*MAX_FRAGS+j]) all = 1'b0;
			end
			if (!done && r < 32'(active_q) && all) begin
				done = 1'b1;
				res_nx.hit = 1'b1;
				res_nx.hit_rule = 4'(r);
				res_nx.hit_tag = tag_q[r];
				res_nx.hit_score = score_q[r];
				res_nx.hit_status = status_q[r];
			end
		end
	end

	// Hold table, flags and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			found_q  <= '0;
			seen_q   <= '0;
			res_v_q  <= 1'b0;
			for (int s = 0; s < NSLOT; s++) len_q[s] <= '0;
			for (int r = 0; r < MAX_RULES; r++) begin
				score_q[r] <= '0; status_q[r] <= '0; cnt_q[r] <= '0; tag_q[r] <= '0;
			end
		end else begin
			if (cfg_valid) active_q <= cfg_data;
			if (res_v_q && !out_stall) res_v_q <= 1'b0;
			if (last_sub) begin
				res_v_q <= 1'b1;
				found_q <= '0;
				seen_q  <= '0;
			end else if (subj) begin
				found_q <= found_nx;
				seen_q  <= seen_nx;
			end
			if (acc && in_data.req_type == REQ_HEADER && addr_ok_r) begin
				score_q[in_data.rule_index]  <= in_data.rule_score;
				status_q[in_data.rule_index] <= in_data.rule_status;
				cnt_q[in_data.rule_index] <= (32'(in_data.frag_count) > MAX_FRAGS) ?
					3'(MAX_FRAGS) : in_data.frag_count;
				tag_q[in_data.rule_index] <= in_data.rule_tag;
			end
			if (acc && in_data.req_type == REQ_LENGTH && addr_ok_f) begin
				len_q[slot] <= (32'(in_data.frag_length) > MAX_FRAG_LEN) ?
					LW'(MAX_FRAG_LEN) : LW'(in_data.frag_length);
			end
		end
	end

	// Register the result.
	always_ff @(posedge clk) begin
		if (last_sub) res_q <= res_nx;
	end

	assign out_valid = res_v_q;
	assign out_data  = res_q;
endmodule
`default_nettype wire

@@ design/mpm_checker.sv @@
// Checker: port-level properties of the matcher, bound to the top level.
`default_nettype none
module mpm_checker import mpm_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);
	// A miss reports a zero tag and score.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_tag == '0 && out_data.hit_score == '0)
		else $error("miss carries nonzero fields");
	// A last subject byte gives a result next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_SUBJECT && in_data.last_byte
		|=> out_valid) else $error("missing result");
	// No stall on input while output is empty.
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall) else $error("spurious stall");
	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
endmodule
bind multi_pattern_and_rule_matcher_unit mpm_checker u_chk (.*);
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for the AND-rule matcher: directed table, then random rule sets and subjects.
`default_nettype none
module testbench;
	import mpm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NR = MAX_RULES_D;
	localparam int NF = MAX_FRAGS_D;
	localparam int NL = MAX_FRAG_LEN_D;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [4:0] cfg_data;

	multi_pattern_and_rule_matcher_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow copy of the rule table and subject state
	logic [7:0]  pat_mem [NR*NF][NL];
	bit          pat_written [NR*NF][NL];
	logic [4:0]  frag_len [NR*NF];
	logic [7:0]  rule_score_m [NR];
	logic [7:0]  rule_status_m [NR];
	logic [2:0]  rule_count_m [NR];
	logic [15:0] rule_tag_m [NR];
	logic [7:0]  window [NL];
	int          seen_cnt;
	bit          found [NR*NF];
	logic [4:0]  active_cnt;

	out_item_t   pending_results [$];
	int          err_cnt;
	int          req_cnt;
	bit          typed_next;
	out_item_t   typed_result;
	bit          rx_fast;
	bit          tx_fast;
	int          rx_wait = 0;
	bit          rx_acc = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// Apply one accepted request to the shadow state; returns 1 when it yields a result
	function automatic bit predict_request(input in_item_t it, output out_item_t res);
		int slot;
		int lim;
		bit all;
		res = '0;
		case (req_type_t'(it.req_type))
			REQ_HEADER: begin
				rule_score_m[it.rule_index]  = it.rule_score;
				rule_status_m[it.rule_index] = it.rule_status;
				rule_count_m[it.rule_index]  = (it.frag_count > NF) ? 3'(NF) : it.frag_count;
				rule_tag_m[it.rule_index]    = it.rule_tag;
				return 1'b0;
			end
			REQ_PATTERN: begin
				slot = it.rule_index * NF + it.frag_index;
				pat_mem[slot][it.byte_pos]     = it.byte_value;
				pat_written[slot][it.byte_pos] = 1'b1;
				return 1'b0;
			end
			REQ_LENGTH: begin
				slot = it.rule_index * NF + it.frag_index;
				frag_len[slot] = (it.frag_length > NL) ? 5'(NL) : it.frag_length;
				return 1'b0;
			end
			default: begin
				for (int i = NL - 1; i > 0; i--) window[i] = window[i-1];
				window[0] = it.byte_value;
				if (seen_cnt < NL) seen_cnt++;
				// mark every fragment that ends at the newest byte
				for (int s = 0; s < NR*NF; s++) begin
					all = 1'b1;
					if (frag_len[s] != 0) begin
						if (seen_cnt < frag_len[s]) all = 1'b0;
						else
							for (int k = 0; k < frag_len[s]; k++)
								if (pat_mem[s][k] != window[frag_len[s]-1-k]) all = 1'b0;
					end
					if (all) found[s] = 1'b1;
				end
				if (!it.last_byte) return 1'b0;
				lim = (active_cnt > NR) ? NR : active_cnt;
				for (int r = 0; r < lim; r++) begin
					all = rule_count_m[r] != 0;
					for (int j = 0; j < rule_count_m[r]; j++)
						if (!found[r*NF + j]) all = 1'b0;
					if (all) begin
						res.hit = 1'b1;
						res.hit_rule = 4'(r);
						res.hit_tag = rule_tag_m[r];
						res.hit_score = rule_score_m[r];
						res.hit_status = rule_status_m[r];
						break;
					end
				end
				for (int i = 0; i < NL; i++) window[i] = 8'h00;
				for (int s = 0; s < NR*NF; s++) found[s] = 1'b0;
				seen_cnt = 0;
				return 1'b1;
			end
		endcase
	endfunction

	// Check results first, then record the request accepted at this edge
	always @(posedge clk) begin
		out_item_t want;
		out_item_t res;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(out_data), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.hit !== want.hit)
					report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
				if (out_data.hit_rule !== want.hit_rule)
					report_mismatch("hit_rule", 32'(out_data.hit_rule), 32'(want.hit_rule));
				if (out_data.hit_tag !== want.hit_tag)
					report_mismatch("hit_tag", 32'(out_data.hit_tag), 32'(want.hit_tag));
				if (out_data.hit_score !== want.hit_score)
					report_mismatch("hit_score", 32'(out_data.hit_score),
						32'(want.hit_score));
				if (out_data.hit_status !== want.hit_status)
					report_mismatch("hit_status", 32'(out_data.hit_status),
						32'(want.hit_status));
			end
		end
		rx_acc <= out_valid && !out_stall;
		if (in_valid && !in_stall) begin
			req_cnt++;
			if (predict_request(in_data, res))
				pending_results.push_back(typed_next ? typed_result : res);
		end
		if (cfg_valid && cfg_ready) active_cnt = cfg_data;
	end

	// Receiver stall: draw a wait after each result, then hold off for it
	always @(negedge clk) begin
		if (rx_acc)
			rx_wait = rx_fast ? 0 : $urandom_range(0, 11);
		else if (rx_wait > 0)
			rx_wait = rx_wait - 1;
		out_stall <= (rx_wait > 0);
	end

	function automatic in_item_t rand_item();
		in_item_t it;
		it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
		return it;
	endfunction

	// Drive one request after a random gap and hold it until accepted
	task automatic send_req(input in_item_t it, input bit typed = 1'b0,
			input out_item_t texp = '0);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		typed_next = typed;
		typed_result = texp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stop sending and wait until every outstanding result has arrived
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_active(input logic [4:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_typed(input req_type_t t, input int r, input int f, input int pos,
			input int bval, input int flen, input int cnt, input int sc, input int st,
			input int tg, input bit last);
		in_item_t it;
		it = rand_item();
		it.req_type = t;
		it.rule_index = 4'(r);
		it.frag_index = 2'(f);
		it.byte_pos = 4'(pos);
		it.byte_value = 8'(bval);
		it.frag_length = 5'(flen);
		it.frag_count = 3'(cnt);
		it.rule_score = 8'(sc);
		it.rule_status = 8'(st);
		it.rule_tag = 16'(tg);
		it.last_byte = last;
		send_req(it);
	endtask

	function automatic logic [7:0] pick_byte();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h41 + 8'($urandom_range(0, 3));
	endfunction

	// Set a fragment length, first writing any unwritten pattern bytes it would expose
	task automatic set_length(input int r, input int f, input int flen);
		int eff;
		eff = (flen > NL) ? NL : flen;
		for (int k = 0; k < eff; k++)
			if (!pat_written[r*NF + f][k])
				send_typed(REQ_PATTERN, r, f, k, int'(pick_byte()), 0, 0, 0, 0, 0,
					1'($urandom));
		send_typed(REQ_LENGTH, r, f, 0, 0, flen, 0, 0, 0, 0, 1'($urandom));
	endtask

	task automatic load_rule(input int r);
		int flen;
		send_typed(REQ_HEADER, r, $urandom, $urandom, $urandom, $urandom,
			($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
			$urandom, $urandom, $urandom, 1'($urandom));
		for (int f = 0; f < NF; f++) begin
			case ($urandom_range(0, 9))
				0: flen = 0;
				1: flen = $urandom_range(NL, 31);
				2: flen = $urandom_range(5, NL);
				default: flen = $urandom_range(1, 4);
			endcase
			for (int k = 0; k < ((flen > NL) ? NL : flen); k++)
				if ($urandom_range(0, 1))
					send_typed(REQ_PATTERN, r, f, k, int'(pick_byte()), 0, 0, 0, 0, 0,
						1'($urandom));
			set_length(r, f, flen);
		end
	endtask

	// Build a subject that holds most fragments of one rule, with filler between
	task automatic send_subject(input int r);
		logic [7:0] bytes_q [$];
		int slot;
		for (int f = 0; f < NF; f++) begin
			slot = r*NF + f;
			repeat ($urandom_range(0, 3)) bytes_q.push_back(pick_byte());
			if ($urandom_range(0, 9) < 8)
				for (int k = 0; k < frag_len[slot]; k++) bytes_q.push_back(pat_mem[slot][k]);
		end
		if (bytes_q.size() == 0) bytes_q.push_back(pick_byte());
		foreach (bytes_q[i]) begin
			// occasionally rewrite a header in the middle of the subject
			if ($urandom_range(0, 39) == 0)
				send_typed(REQ_HEADER, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, 1'($urandom));
			send_typed(REQ_SUBJECT, $urandom, $urandom, $urandom, int'(bytes_q[i]), $urandom,
				$urandom, $urandom, $urandom, $urandom, i == bytes_q.size() - 1);
		end
	endtask

	task automatic send_noise();
		in_item_t it;
		it = rand_item();
		if (it.req_type == REQ_LENGTH)
			set_length(int'(it.rule_index), int'(it.frag_index), int'(it.frag_length));
		else
			send_req(it);
	endtask

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	function automatic stim_row_t row(input req_type_t t, input int r, input int f,
			input int pos, input int bval, input int flen, input int cnt, input int sc,
			input int st, input int tg, input bit last, input bit typed = 1'b0,
			input out_item_t want = '0);
		stim_row_t s;
		s.it = '{req_type: t, rule_index: 4'(r), frag_index: 2'(f), byte_pos: 4'(pos),
			byte_value: 8'(bval), frag_length: 5'(flen), rule_score: 8'(sc),
			rule_status: 8'(st), frag_count: 3'(cnt), rule_tag: 16'(tg), last_byte: last};
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	initial begin
		stim_row_t dir_tab [$];
		logic [4:0] cfg_vals [$];
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rx_fast = 1'b0;
		tx_fast = 1'b0;
		typed_next = 1'b0;
		err_cnt = 0;
		req_cnt = 0;
		seen_cnt = 0;
		active_cnt = '0;
		for (int s = 0; s < NR*NF; s++) begin
			frag_len[s] = '0;
			found[s] = 1'b0;
			for (int k = 0; k < NL; k++) begin
				pat_mem[s][k] = '0;
				pat_written[s][k] = 1'b0;
			end
		end
		for (int r = 0; r < NR; r++) begin
			rule_score_m[r] = '0;
			rule_status_m[r] = '0;
			rule_count_m[r] = '0;
			rule_tag_m[r] = '0;
		end
		for (int i = 0; i < NL; i++) window[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_active(5'd16);
		// empty table misses; zero-length fragments always hit; short subject misses
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'h00, 0, 0, 0, 0, 0, 1, 1, '0));
		dir_tab.push_back(row(REQ_HEADER, 0, 0, 0, 0, 0, 7, 255, 2, 16'hFFFF, 1));
		dir_tab.push_back(row(REQ_SUBJECT, 15, 3, 15, 8'hFF, 31, 7, 255, 255, 16'hFFFF, 1,
			1, '{1'b1, 4'd0, 16'hFFFF, 8'hFF, 8'h02}));
		dir_tab.push_back(row(REQ_HEADER, 15, 3, 15, 255, 31, 1, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_HEADER, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'h00, 0, 0, 0, 0, 0, 1,
			1, '{1'b1, 4'd15, 16'h0000, 8'h00, 8'h00}));
		dir_tab.push_back(row(REQ_PATTERN, 1, 0, 0, 8'hAB, 0, 0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_PATTERN, 1, 0, 1, 8'hCD, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_LENGTH, 1, 0, 0, 0, 2, 0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_HEADER, 1, 0, 0, 0, 0, 1, 8'h10, 2, 16'h1234, 0));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'hAB, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'hCD, 0, 0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'hCD, 0, 0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_PATTERN, 2, 3, 15, 8'h00, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_HEADER, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'hAB, 0, 0, 0, 0, 0, 1));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'hAB, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(REQ_HEADER, 1, 0, 0, 0, 0, 1, 8'h77, 0, 16'h0042, 0));
		dir_tab.push_back(row(REQ_SUBJECT, 0, 0, 0, 8'hCD, 0, 0, 0, 0, 0, 1));
		foreach (dir_tab[i]) send_req(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
		@(negedge clk);
		typed_next = 1'b0;

		// random phases: reconfigure, load rules, stream subjects
		cfg_vals = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17};
		phase = 0;
		while (req_cnt < 1750) begin
			if (phase % 3 == 0)
				write_active((phase / 3 < cfg_vals.size()) ? cfg_vals[phase / 3]
					: 5'($urandom_range(0, 31)));
			if (phase == 4) drain();
			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3)) load_rule($urandom_range(0, NR - 1));
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					send_subject($urandom_range(0, NR - 1));
			end
			phase++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
